FILE: design/acs_pkg.sv
// types, code tables and shaping functions for the arabic contextual shaper
`timescale 1ns / 1ps
`default_nettype none
package acs_pkg;

  localparam logic [15:0] FIRST_LETTER = 16'h0621;
  localparam logic [15:0] LAST_LETTER  = 16'h064a;
  localparam logic [15:0] LAM          = 16'h0644;
  localparam logic [15:0] ALEF_MADDA   = 16'h0622;
  localparam logic [15:0] ALEF_HAMZA_A = 16'h0623;
  localparam logic [15:0] ALEF_HAMZA_B = 16'h0625;
  localparam logic [15:0] ALEF         = 16'h0627;
  localparam logic [15:0] LIG_MADDA    = 16'hfef5;
  localparam logic [15:0] LIG_HAMZA_A  = 16'hfef7;
  localparam logic [15:0] LIG_HAMZA_B  = 16'hfef9;
  localparam logic [15:0] LIG_ALEF     = 16'hfefb;

  localparam int LETTER_COUNT = 42;
  localparam int ROW_W        = 6;
  localparam int FORM_COLS    = 4;
  localparam int FIFO_DEPTH   = 4;
  localparam int PTR_W        = 2;
  localparam int LEVEL_W      = 3;

  // column order: joined before only, joined after only, both, neither
  localparam logic [15:0] FORM_TABLE [0:LETTER_COUNT-1][0:FORM_COLS-1] = '{
    '{16'hfe80, 16'hfe80, 16'hfe80, 16'hfe80}, '{16'hfe82, 16'hfe81, 16'hfe82, 16'hfe81},
    '{16'hfe84, 16'hfe83, 16'hfe84, 16'hfe83}, '{16'hfe86, 16'hfe85, 16'hfe86, 16'hfe85},
    '{16'hfe88, 16'hfe87, 16'hfe88, 16'hfe87}, '{16'hfe8a, 16'hfe8b, 16'hfe8c, 16'hfe89},
    '{16'hfe8e, 16'hfe8d, 16'hfe8e, 16'hfe8d}, '{16'hfe90, 16'hfe91, 16'hfe92, 16'hfe8f},
    '{16'hfe94, 16'hfe93, 16'hfe93, 16'hfe93}, '{16'hfe96, 16'hfe97, 16'hfe98, 16'hfe95},
    '{16'hfe9a, 16'hfe9b, 16'hfe9c, 16'hfe99}, '{16'hfe9e, 16'hfe9f, 16'hfea0, 16'hfe9d},
    '{16'hfea2, 16'hfea3, 16'hfea4, 16'hfea1}, '{16'hfea6, 16'hfea7, 16'hfea8, 16'hfea5},
    '{16'hfeaa, 16'hfea9, 16'hfeaa, 16'hfea9}, '{16'hfeac, 16'hfeab, 16'hfeac, 16'hfeab},
    '{16'hfeae, 16'hfead, 16'hfeae, 16'hfead}, '{16'hfeb0, 16'hfeaf, 16'hfeb0, 16'hfeaf},
    '{16'hfeb2, 16'hfeb3, 16'hfeb4, 16'hfeb1}, '{16'hfeb6, 16'hfeb7, 16'hfeb8, 16'hfeb5},
    '{16'hfeba, 16'hfebb, 16'hfebc, 16'hfeb9}, '{16'hfebe, 16'hfebf, 16'hfec0, 16'hfebd},
    '{16'hfec2, 16'hfec3, 16'hfec4, 16'hfec1}, '{16'hfec6, 16'hfec7, 16'hfec8, 16'hfec5},
    '{16'hfeca, 16'hfecb, 16'hfecc, 16'hfec9}, '{16'hfece, 16'hfecf, 16'hfed0, 16'hfecd},
    '{16'h063b, 16'h063b, 16'h063b, 16'h063b}, '{16'h063c, 16'h063c, 16'h063c, 16'h063c},
    '{16'h063d, 16'h063d, 16'h063d, 16'h063d}, '{16'h063e, 16'h063e, 16'h063e, 16'h063e},
    '{16'h063f, 16'h063f, 16'h063f, 16'h063f}, '{16'h0640, 16'h0640, 16'h0640, 16'h0640},
    '{16'hfed2, 16'hfed3, 16'hfed4, 16'hfed1}, '{16'hfed6, 16'hfed7, 16'hfed8, 16'hfed5},
    '{16'hfeda, 16'hfedb, 16'hfedc, 16'hfed9}, '{16'hfede, 16'hfedf, 16'hfee0, 16'hfedd},
    '{16'hfee2, 16'hfee3, 16'hfee4, 16'hfee1}, '{16'hfee6, 16'hfee7, 16'hfee8, 16'hfee5},
    '{16'hfeea, 16'hfeeb, 16'hfeec, 16'hfee9}, '{16'hfeee, 16'hfeed, 16'hfeee, 16'hfeed},
    '{16'hfef0, 16'hfeef, 16'hfef0, 16'hfeef}, '{16'hfef2, 16'hfef3, 16'hfef4, 16'hfef1}
  };

  typedef enum logic [1:0] {
    COL_BEFORE = 2'd0,
    COL_AFTER  = 2'd1,
    COL_BOTH   = 2'd2,
    COL_NONE   = 2'd3
  } form_col_t;

  typedef struct packed {
    logic [15:0] code;
    logic        done;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic joins_forward(input logic [15:0] c);
    logic r;
    case (c) inside
      16'h062c, 16'h062d, 16'h062e, 16'h0647, 16'h0639, 16'h063a, 16'h0641, 16'h0642,
      16'h062b, 16'h0635, 16'h0636, 16'h0637, 16'h0643, 16'h0645, 16'h0646, 16'h062a,
      16'h0644, 16'h0628, 16'h064a, 16'h0633, 16'h0634, 16'h0638, 16'h0626: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic joins_any(input logic [15:0] c);
    logic r;
    case (c) inside
      16'h0627, 16'h0623, 16'h0625, 16'h0622, 16'h062f, 16'h0630, 16'h0631, 16'h0632,
      16'h0648, 16'h0624, 16'h0629, 16'h0649: r = 1'b1;
      default: r = joins_forward(c);
    endcase
    return r;
  endfunction

  function automatic logic is_alef(input logic [15:0] c);
    return (c == ALEF_MADDA) || (c == ALEF_HAMZA_A) || (c == ALEF_HAMZA_B) || (c == ALEF);
  endfunction

  function automatic logic [15:0] lam_alef(input logic [15:0] alef_code, input logic fin);
    logic [15:0] base;
    case (alef_code)
      ALEF_MADDA:   base = LIG_MADDA;
      ALEF_HAMZA_A: base = LIG_HAMZA_A;
      ALEF_HAMZA_B: base = LIG_HAMZA_B;
      default:      base = LIG_ALEF;
    endcase
    return base + {15'd0, fin};
  endfunction

  function automatic logic [15:0] shape(input logic [15:0] prev, input logic [15:0] cur,
                                        input logic [15:0] next);
    logic        prev_joins;
    logic        after;
    form_col_t   col;
    logic [15:0] diff;
    logic [15:0] r;
    prev_joins = joins_forward(prev);
    after      = joins_any(next);
    diff       = cur - FIRST_LETTER;
    if (prev_joins && after) col = COL_BOTH;
    else if (prev_joins) col = COL_BEFORE;
    else if (after) col = COL_AFTER;
    else col = COL_NONE;
    if (cur < FIRST_LETTER || cur > LAST_LETTER) r = cur;
    else r = FORM_TABLE[diff[ROW_W-1:0]][col];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/acs_result_fifo.sv
// result queue taking up to two results per cycle and giving one
`timescale 1ns / 1ps
`default_nettype none
module acs_result_fifo import acs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire push_t              push,
  input  wire logic               pop,
  output result_t                 head,
  output logic                    not_empty,
  output logic [LEVEL_W-1:0]      level
);

  result_t            mem [0:FIFO_DEPTH-1];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr_next;
  logic [LEVEL_W-1:0] level_next;
  logic               pop_ok;

  assign not_empty = (level != '0);
  assign head      = mem[rd_ptr];
  assign pop_ok    = pop && not_empty;

  always_comb begin
    wr_ptr_next = wr_ptr + PTR_W'(push.count);
    level_next  = level + LEVEL_W'(push.count) - LEVEL_W'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.first;
    if (push.count == 2'd2) mem[PTR_W'(wr_ptr + 1'b1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      level  <= level_next;
      if (pop_ok) rd_ptr <= rd_ptr + 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: design/arabic_contextual_shaper.sv
// arabic contextual shaper: presentation forms and lam-alef ligatures
// a result enters the result queue at the clock edge that accepts the request
//   completing it; each code is held until its successor request arrives
// throughput: one request per cycle while the result queue has room for two
//   results; a request giving two results is absorbed by the four-entry result queue
// reset: synchronous, clears string state and empties the queue
`timescale 1ns / 1ps
`default_nettype none
module arabic_contextual_shaper import acs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] code_point,
  input  wire logic        end_of_string,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      shaped_code,
  output logic             string_done
);

  logic [15:0]        previous_code;
  logic [15:0]        held_code;
  logic               held_valid;
  logic               inside_string;
  logic [15:0]        previous_code_next;
  logic [15:0]        held_code_next;
  logic               held_valid_next;
  logic               inside_string_next;
  logic               accept;
  logic               lam_alef_hit;
  push_t              push;
  result_t            head;
  logic [LEVEL_W-1:0] level;

  assign in_ready     = (level <= LEVEL_W'(FIFO_DEPTH - 2));
  assign accept       = in_valid && in_ready;
  assign lam_alef_hit = (held_code == LAM) && is_alef(code_point);

  always_comb begin
    previous_code_next = previous_code;
    held_code_next     = held_code;
    held_valid_next    = held_valid;
    inside_string_next = inside_string;
    push               = '0;
    if (accept) begin
      if (!held_valid) begin
        if (end_of_string) begin
          push.count      = 2'd1;
          push.first.code = inside_string ? shape(previous_code, code_point, 16'h0000)
                                          : code_point;
          push.first.done = 1'b1;
        end else begin
          held_code_next     = code_point;
          held_valid_next    = 1'b1;
          inside_string_next = 1'b1;
        end
      end else if (lam_alef_hit) begin
        push.count         = 2'd1;
        push.first.code    = lam_alef(code_point, joins_forward(previous_code));
        push.first.done    = end_of_string;
        previous_code_next = code_point;
        held_code_next     = '0;
        held_valid_next    = 1'b0;
      end else begin
        push.count         = end_of_string ? 2'd2 : 2'd1;
        push.first.code    = shape(previous_code, held_code, code_point);
        push.first.done    = 1'b0;
        push.second.code   = shape(held_code, code_point, 16'h0000);
        push.second.done   = 1'b1;
        previous_code_next = held_code;
        held_code_next     = code_point;
      end
      // string boundary
      if (end_of_string) begin
        previous_code_next = '0;
        held_code_next     = '0;
        held_valid_next    = 1'b0;
        inside_string_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_code <= '0;
      held_code     <= '0;
      held_valid    <= 1'b0;
      inside_string <= 1'b0;
    end else begin
      previous_code <= previous_code_next;
      held_code     <= held_code_next;
      held_valid    <= held_valid_next;
      inside_string <= inside_string_next;
    end
  end

  acs_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (out_ready),
    .head      (head),
    .not_empty (out_valid),
    .level     (level)
  );

  assign shaped_code = head.code;
  assign string_done = head.done;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_W'(FIFO_DEPTH))
    else $error("result queue over capacity");

  a_held_in_string: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> inside_string)
    else $error("held code outside a string");

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_string |=> !held_valid && !inside_string && previous_code == '0)
    else $error("state not cleared after end of string");

  a_first_holds: assert property (@(posedge clk) disable iff (rst)
    accept && !held_valid && !end_of_string |=> held_valid && level == $past(level)
      - LEVEL_W'($past(out_valid && out_ready)))
    else $error("first code of string not held");

endmodule
`default_nettype wire

FILE: tb/arabic_contextual_shaper_tb.sv
// self-checking testbench for the arabic contextual shaper: directed table, then random strings
`timescale 1ns / 1ps
`default_nettype none
module arabic_contextual_shaper_tb;
  import acs_pkg::*;

  localparam logic [15:0] LETTER_FIRST  = 16'h0621;
  localparam logic [15:0] LETTER_LAST   = 16'h064a;
  localparam logic [15:0] LAM_CODE      = 16'h0644;
  localparam logic [15:0] LIGATURE_BASE = 16'hfef5;
  localparam logic [15:0] NO_CODE       = 16'h0000;
  localparam int RANDOM_ITEMS   = 750;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [15:0] ALEF_KINDS [4] = '{16'h0622, 16'h0623, 16'h0625, 16'h0627};

  localparam logic [15:0] FORWARD_JOINERS [23] = '{
    16'h062c, 16'h062d, 16'h062e, 16'h0647, 16'h0639, 16'h063a, 16'h0641, 16'h0642,
    16'h062b, 16'h0635, 16'h0636, 16'h0637, 16'h0643, 16'h0645, 16'h0646, 16'h062a,
    16'h0644, 16'h0628, 16'h064a, 16'h0633, 16'h0634, 16'h0638, 16'h0626
  };

  // letters that join to the previous one but not to the next
  localparam logic [15:0] RIGHT_JOINERS [12] = '{
    16'h0627, 16'h0623, 16'h0625, 16'h0622, 16'h062f, 16'h0630, 16'h0631, 16'h0632,
    16'h0648, 16'h0624, 16'h0629, 16'h0649
  };

  localparam logic [15:0] GLYPH_FORMS [42][4] = '{
    '{16'hfe80, 16'hfe80, 16'hfe80, 16'hfe80}, '{16'hfe82, 16'hfe81, 16'hfe82, 16'hfe81},
    '{16'hfe84, 16'hfe83, 16'hfe84, 16'hfe83}, '{16'hfe86, 16'hfe85, 16'hfe86, 16'hfe85},
    '{16'hfe88, 16'hfe87, 16'hfe88, 16'hfe87}, '{16'hfe8a, 16'hfe8b, 16'hfe8c, 16'hfe89},
    '{16'hfe8e, 16'hfe8d, 16'hfe8e, 16'hfe8d}, '{16'hfe90, 16'hfe91, 16'hfe92, 16'hfe8f},
    '{16'hfe94, 16'hfe93, 16'hfe93, 16'hfe93}, '{16'hfe96, 16'hfe97, 16'hfe98, 16'hfe95},
    '{16'hfe9a, 16'hfe9b, 16'hfe9c, 16'hfe99}, '{16'hfe9e, 16'hfe9f, 16'hfea0, 16'hfe9d},
    '{16'hfea2, 16'hfea3, 16'hfea4, 16'hfea1}, '{16'hfea6, 16'hfea7, 16'hfea8, 16'hfea5},
    '{16'hfeaa, 16'hfea9, 16'hfeaa, 16'hfea9}, '{16'hfeac, 16'hfeab, 16'hfeac, 16'hfeab},
    '{16'hfeae, 16'hfead, 16'hfeae, 16'hfead}, '{16'hfeb0, 16'hfeaf, 16'hfeb0, 16'hfeaf},
    '{16'hfeb2, 16'hfeb3, 16'hfeb4, 16'hfeb1}, '{16'hfeb6, 16'hfeb7, 16'hfeb8, 16'hfeb5},
    '{16'hfeba, 16'hfebb, 16'hfebc, 16'hfeb9}, '{16'hfebe, 16'hfebf, 16'hfec0, 16'hfebd},
    '{16'hfec2, 16'hfec3, 16'hfec4, 16'hfec1}, '{16'hfec6, 16'hfec7, 16'hfec8, 16'hfec5},
    '{16'hfeca, 16'hfecb, 16'hfecc, 16'hfec9}, '{16'hfece, 16'hfecf, 16'hfed0, 16'hfecd},
    '{16'h063b, 16'h063b, 16'h063b, 16'h063b}, '{16'h063c, 16'h063c, 16'h063c, 16'h063c},
    '{16'h063d, 16'h063d, 16'h063d, 16'h063d}, '{16'h063e, 16'h063e, 16'h063e, 16'h063e},
    '{16'h063f, 16'h063f, 16'h063f, 16'h063f}, '{16'h0640, 16'h0640, 16'h0640, 16'h0640},
    '{16'hfed2, 16'hfed3, 16'hfed4, 16'hfed1}, '{16'hfed6, 16'hfed7, 16'hfed8, 16'hfed5},
    '{16'hfeda, 16'hfedb, 16'hfedc, 16'hfed9}, '{16'hfede, 16'hfedf, 16'hfee0, 16'hfedd},
    '{16'hfee2, 16'hfee3, 16'hfee4, 16'hfee1}, '{16'hfee6, 16'hfee7, 16'hfee8, 16'hfee5},
    '{16'hfeea, 16'hfeeb, 16'hfeec, 16'hfee9}, '{16'hfeee, 16'hfeed, 16'hfeee, 16'hfeed},
    '{16'hfef0, 16'hfeef, 16'hfef0, 16'hfeef}, '{16'hfef2, 16'hfef3, 16'hfef4, 16'hfef1}
  };

  typedef struct packed {
    logic [15:0] code;
    logic        last;
    logic        typed;
    logic [15:0] want;
    logic        want_done;
  } script_row_t;

  localparam script_row_t OPENING_SCRIPT [24] = '{
    '{16'hffff, 1'b1, 1'b1, 16'hffff, 1'b1},
    '{16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1},
    '{16'h0628, 1'b1, 1'b1, 16'h0628, 1'b1},
    '{16'h0644, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0627, 1'b1, 1'b1, 16'hfefb, 1'b1},
    '{16'h0621, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h064a, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{16'h0628, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0644, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0622, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0628, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{16'h0644, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0623, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0644, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0625, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{16'h0639, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0620, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h064b, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0644, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0644, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{16'h0633, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0644, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0627, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0640, 1'b1, 1'b0, 16'h0000, 1'b0}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] code_point = 16'h0000;
  logic        end_of_string = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] shaped_code;
  logic        string_done;

  // shaper state as the predictor sees it
  logic [15:0] prior_letter = 16'h0000;
  logic [15:0] waiting_letter = 16'h0000;
  logic        waiting_live = 1'b0;
  logic        in_word = 1'b0;

  result_t pending_glyphs[$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  logic    send_calm = 1'b0;
  logic    drain_calm = 1'b0;
  logic    hold_drain = 1'b0;

  arabic_contextual_shaper DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .code_point    (code_point),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .shaped_code   (shaped_code),
    .string_done   (string_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic links_forward(input logic [15:0] c);
    for (int i = 0; i < 23; i++) if (FORWARD_JOINERS[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic links_any(input logic [15:0] c);
    for (int i = 0; i < 12; i++) if (RIGHT_JOINERS[i] == c) return 1'b1;
    return links_forward(c);
  endfunction

  function automatic int alef_slot(input logic [15:0] c);
    for (int i = 0; i < 4; i++) if (ALEF_KINDS[i] == c) return i;
    return -1;
  endfunction

  function automatic logic [15:0] contextual_form(input logic [15:0] prev,
                                                  input logic [15:0] cur,
                                                  input logic [15:0] next);
    logic      joined_before;
    logic      joined_after;
    form_col_t col;
    if (cur < LETTER_FIRST || cur > LETTER_LAST) return cur;
    joined_before = links_forward(prev);
    joined_after  = links_any(next);
    if (joined_before && joined_after) col = COL_BOTH;
    else if (joined_before) col = COL_BEFORE;
    else if (joined_after) col = COL_AFTER;
    else col = COL_NONE;
    return GLYPH_FORMS[int'(cur - LETTER_FIRST)][int'(col)];
  endfunction

  function automatic void clear_word();
    prior_letter   = 16'h0000;
    waiting_letter = 16'h0000;
    waiting_live   = 1'b0;
    in_word        = 1'b0;
  endfunction

  // returns how many glyphs the request releases
  function automatic int advance_shaper(input logic [15:0] c, input logic last,
                                        output result_t g0, output result_t g1);
    int slot;
    g0 = '0;
    g1 = '0;
    slot = alef_slot(c);
    if (!waiting_live) begin
      if (last) begin
        g0 = '{code: (in_word ? contextual_form(prior_letter, c, NO_CODE) : c), done: 1'b1};
        clear_word();
        return 1;
      end
      waiting_letter = c;
      waiting_live   = 1'b1;
      in_word        = 1'b1;
      return 0;
    end
    if (waiting_letter == LAM_CODE && slot >= 0) begin
      g0.code = LIGATURE_BASE + 16'(2 * slot) + {15'd0, links_forward(prior_letter)};
      g0.done = last;
      if (last) begin
        clear_word();
      end else begin
        prior_letter   = c;
        waiting_live   = 1'b0;
        waiting_letter = 16'h0000;
      end
      return 1;
    end
    g0 = '{code: contextual_form(prior_letter, waiting_letter, c), done: 1'b0};
    if (last) begin
      g1 = '{code: contextual_form(waiting_letter, c, NO_CODE), done: 1'b1};
      clear_word();
      return 2;
    end
    prior_letter   = waiting_letter;
    waiting_letter = c;
    return 1;
  endfunction

  function automatic logic [15:0] pick_code(input logic after_lam);
    int roll;
    roll = $urandom_range(0, 99);
    if (after_lam && roll < 50) return ALEF_KINDS[$urandom_range(0, 3)];
    if (roll < 60) return LETTER_FIRST + 16'($urandom_range(0, 41));
    if (roll < 72) return ALEF_KINDS[$urandom_range(0, 3)];
    if (roll < 84) return LAM_CODE;
    if (roll < 90) return 16'($urandom_range(16'h0618, 16'h0654));
    return 16'($urandom());
  endfunction

  task automatic offer_code(input logic [15:0] c, input logic last, input logic typed,
                            input logic [15:0] want, input logic want_done);
    int      gap;
    int      count;
    result_t g0;
    result_t g1;
    gap = send_calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    code_point    <= c;
    end_of_string <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    count = advance_shaper(c, last, g0, g1);
    if (typed) g0 = '{code: want, done: want_done};
    if (count > 0) pending_glyphs.push_back(g0);
    if (count > 1) pending_glyphs.push_back(g1);
  endtask

  task automatic send_random_string(input int len);
    logic [15:0] c;
    logic [15:0] prev_pick;
    prev_pick = 16'h0000;
    for (int k = 0; k < len; k++) begin
      c = pick_code(prev_pick == LAM_CODE);
      offer_code(c, k == len - 1, 1'b0, 16'h0000, 1'b0);
      prev_pick = c;
    end
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_glyphs.size() != 0) @(posedge clk);
  endtask

  task automatic check_glyph(input logic [15:0] code, input logic done);
    result_t want;
    if (pending_glyphs.size() == 0) begin
      if (mismatches < REPORT_LIMIT)
        $display("unexpected result: code %h done %b", code, done);
      mismatches++;
    end else begin
      want = pending_glyphs.pop_front();
      if (want.code !== code || want.done !== done) begin
        if (mismatches < REPORT_LIMIT)
          $display("mismatch: expected code %h done %b, got code %h done %b",
                   want.code, want.done, code, done);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : result_drain
    int stall;
    int taken;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_drain) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_drain = 1'b0;
      end
      if (taken % 32 == 0) drain_calm = ($urandom_range(0, 3) == 0);
      stall = drain_calm ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_glyph(shaped_code, string_done);
      taken++;
    end
  end

  initial begin : request_source
    int   sent;
    int   len;
    logic held_off;
    sent     = 0;
    held_off = 1'b0;
    clear_word();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (OPENING_SCRIPT[i])
      offer_code(OPENING_SCRIPT[i].code, OPENING_SCRIPT[i].last, OPENING_SCRIPT[i].typed,
                 OPENING_SCRIPT[i].want, OPENING_SCRIPT[i].want_done);
    pause_sender();
    while (sent < RANDOM_ITEMS) begin
      if (!held_off && sent >= RANDOM_ITEMS / 2) begin
        // back up the result side while requests keep coming
        pause_sender();
        hold_drain = 1'b1;
        send_calm  = 1'b1;
        send_random_string(24);
        sent += 24;
        held_off = 1'b1;
      end
      len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
      send_calm = ($urandom_range(0, 3) == 0);
      send_random_string(len);
      sent += len;
    end
    in_valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
